[hdl/msbp_pkg.sv]
// ----------------------------------------------------------------------------
// msbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package msbp_pkg;

  localparam int MAX_FIELD_BITS_DEF = 64;
  localparam int VALUE_W            = 64;
  localparam int NBITS_W            = 7;
  localparam int BYTE_W             = 8;
  localparam int PEND_W             = 7;
  localparam int CNT_W              = 3;
  localparam int BUF_W              = VALUE_W + BYTE_W;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // One classified request: value bits already masked and left-aligned.
  typedef struct packed {
    logic               is_flush;
    logic [VALUE_W-1:0] bits;
    logic [NBITS_W-1:0] nbits;
  } msbp_entry_t;

endpackage

[hdl/msbp_front.sv]
// ----------------------------------------------------------------------------
// msbp_front
// Accepts requests, saturates the field width, masks and left-aligns the
// value bits, and drops writes that carry no bits.
// ----------------------------------------------------------------------------
module msbp_front import msbp_pkg::*; #(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [NBITS_W-1:0] nbits_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output msbp_entry_t        q_entry_o
);

  localparam logic [NBITS_W-1:0] MaxBits  = NBITS_W'(MAX_FIELD_BITS);
  localparam logic [NBITS_W-1:0] ValueLen = NBITS_W'(VALUE_W);

  logic [NBITS_W-1:0] nbits_sat;

  always_comb begin
    nbits_sat           = (nbits_i > MaxBits) ? MaxBits : nbits_i;
    q_entry_o.is_flush  = (func_i == FUNC_FLUSH);
    q_entry_o.nbits     = nbits_sat;
    q_entry_o.bits      = value_i << (ValueLen - nbits_sat);
    in_stall_o          = q_full_i;
    q_push_o            = in_valid_i && !q_full_i &&
                          ((func_i == FUNC_FLUSH) || (nbits_sat != '0));
  end

endmodule

[hdl/msbp_queue.sv]
// ----------------------------------------------------------------------------
// msbp_queue
// Short register queue between the front and the back of the packer.
// ----------------------------------------------------------------------------
module msbp_queue import msbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  msbp_entry_t push_entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output msbp_entry_t pop_entry_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(QUEUE_DEPTH);

  msbp_entry_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  always_comb begin
    full_o      = (count_q == Depth);
    valid_o     = (count_q != '0);
    pop_entry_o = mem_q[rd_ptr_q];
    do_push     = push_i && !full_o;
    do_pop      = pop_i && valid_o;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[hdl/msbp_back.sv]
// ----------------------------------------------------------------------------
// msbp_back
// Merges queued requests with the pending bits and emits one byte a cycle
// through the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module msbp_back import msbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  msbp_entry_t       q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o
);

  localparam int RemW = CNT_W;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              last_q, last_d;

  logic [BUF_W-1:0]   load_buf;
  logic [NBITS_W-1:0] load_total;
  logic [CNT_W:0]     load_bytes;
  logic [CNT_W-1:0]   load_cnt;
  logic               can_emit;
  logic               do_load;

  always_comb begin
    load_total = NBITS_W'(cnt_q) + q_entry_i.nbits;
    if (q_entry_i.is_flush) begin
      load_buf   = {pend_q, {(BUF_W-PEND_W){1'b0}}};
      load_bytes = (cnt_q != '0) ? (CNT_W+1)'(1) : '0;
      load_cnt   = '0;
    end else begin
      load_buf   = {pend_q, {(BUF_W-PEND_W){1'b0}}} |
                   ({q_entry_i.bits, {BYTE_W{1'b0}}} >> cnt_q);
      load_bytes = load_total[NBITS_W-1:CNT_W];
      load_cnt   = load_total[CNT_W-1:0];
    end

    can_emit = !out_valid_q || !out_stall_i;
    do_load  = q_valid_i && (rem_q == '0) && ((load_bytes == '0) || can_emit);

    buf_d       = buf_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    if (rem_q != '0) begin
      if (can_emit) begin
        out_valid_d = 1'b1;
        out_byte_d  = buf_q[BUF_W-1 -: BYTE_W];
        last_d      = (rem_q == RemW'(1));
        buf_d       = buf_q << BYTE_W;
        rem_d       = rem_q - 1'b1;
        if (rem_q == RemW'(1)) begin
          pend_d = buf_q[BUF_W-BYTE_W-1 -: PEND_W];
        end
      end
    end else if (do_load) begin
      cnt_d = load_cnt;
      if (load_bytes == '0) begin
        pend_d = load_buf[BUF_W-1 -: PEND_W];
      end else begin
        out_valid_d = 1'b1;
        out_byte_d  = load_buf[BUF_W-1 -: BYTE_W];
        last_d      = (load_bytes == (CNT_W+1)'(1));
        buf_d       = load_buf << BYTE_W;
        rem_d       = RemW'(load_bytes - 1'b1);
        if (load_bytes == (CNT_W+1)'(1)) begin
          pend_d = load_buf[BUF_W-BYTE_W-1 -: PEND_W];
        end
      end
    end
  end

  assign q_pop_o     = do_load;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new request is never taken while bytes of the previous one remain.
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> !do_load)
    else $error("request loaded while bytes were outstanding");

  // Pending bits are left-aligned with zeros below the count.
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> ((pend_q & (7'h7f >> cnt_q)) == '0))
    else $error("stray bits below the pending count");

  // A flush leaves nothing pending.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_load && q_entry_i.is_flush) |=> ((cnt_q == '0) && (pend_q == '0)))
    else $error("flush left pending bits");

  // A byte that is taken without the last mark always has a successor.
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |-> (rem_q != '0))
    else $error("non-final byte without a following byte");

endmodule

[hdl/msb_first_bit_packer_core.sv]
// The first byte of a request passes through the queue, then the output register.
// Throughput: one byte per cycle on the output while it is not stalled; the emit
// stage takes no new write until it has completed the bytes of the last one, and
// the output register and two-entry queue decouple stalls.
// Reset: asynchronous and active low; pending bits, count and queue are cleared.
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Packs variable-width fields into a byte stream, most significant bit first.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core import msbp_pkg::*; #(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [NBITS_W-1:0] nbits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               last_o
);

  msbp_entry_t push_entry, pop_entry;
  logic        q_push, q_full, q_pop, q_valid;

  msbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .value_i    (value_i),
    .nbits_i    (nbits_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  msbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  msbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
